@@ sv/upd_pkg.sv @@
package upd_pkg;

  localparam logic [7:0] PctChar = 8'h25;
  localparam int unsigned MaxOut = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  // one decoded run: up to three bytes caused by one input word
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [1:0]             cnt;   // number of valid bytes, 1..3
    logic                   last;  // run closes the string
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

@@ sv/upd_front.sv @@
module upd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          push_o,
  output upd_pkg::run_t run_o
);
  import upd_pkg::*;

  logic [1:0] pcnt_q, pcnt_d;
  logic [7:0] digit_q, digit_d;
  logic [1:0] n;
  run_t       run;

  always_comb begin
    pcnt_d = pcnt_q;
    digit_d = digit_q;
    n = 2'd0;
    run = '0;

    case (pcnt_q)
      2'd1: begin
        if (is_hex(in_byte_i)) begin
          digit_d = in_byte_i;
          pcnt_d = 2'd2;
        end else begin
          pcnt_d = 2'd0;
          run.data[n] = PctChar;
          n = n + 2'd1;
          if (in_byte_i == PctChar) begin
            pcnt_d = 2'd1;
          end else begin
            run.data[n] = in_byte_i;
            n = n + 2'd1;
          end
        end
      end
      2'd2: begin
        pcnt_d = 2'd0;
        if (is_hex(in_byte_i) && is_hex(digit_q)) begin
          run.data[n] = {hex_val(digit_q), hex_val(in_byte_i)};
          n = n + 2'd1;
        end else begin
          run.data[n] = PctChar;
          n = n + 2'd1;
          run.data[n] = digit_q;
          n = n + 2'd1;
          if (in_byte_i == PctChar) begin
            pcnt_d = 2'd1;
          end else begin
            run.data[n] = in_byte_i;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        pcnt_d = 2'd0;
        if (in_byte_i == PctChar) begin
          pcnt_d = 2'd1;
        end else begin
          run.data[n] = in_byte_i;
          n = n + 2'd1;
        end
      end
    endcase

    // end of string: flush whatever is still held
    if (in_last_i) begin
      if (pcnt_d != 2'd0 && n != 2'd3) begin
        run.data[n] = PctChar;
        n = n + 2'd1;
      end
      if (pcnt_d == 2'd2 && n != 2'd3) begin
        run.data[n] = digit_d;
        n = n + 2'd1;
      end
      pcnt_d = 2'd0;
      digit_d = 8'h00;
    end

    run.cnt = n;
    run.last = in_last_i;
  end

  assign push_o = accept_i && (n != 2'd0);
  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      digit_q <= 8'h00;
    end else if (accept_i) begin
      pcnt_q <= pcnt_d;
      digit_q <= digit_d;
    end
  end

endmodule

@@ sv/upd_queue.sv @@
module upd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upd_pkg::run_t push_run_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output upd_pkg::run_t head_o
);
  import upd_pkg::*;

  run_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   fill_q;

  assign full_o  = (fill_q == QPtrW'(0) + (QPtrW+1)'(QDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

@@ sv/upd_back.sv @@
module upd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  upd_pkg::run_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          string_end_o,
  output logic          run_end_o
);
  import upd_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       send_q, rend_q;
  logic       load, final_byte;

  // refill the output register whenever it is empty or being drained
  assign load = !empty_i && (!valid_q || out_ready_i);
  assign final_byte = (idx_q == head_i.cnt - 2'd1);
  assign pop_o = load && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      rend_q <= final_byte;
      send_q <= final_byte && head_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o = byte_q;
  assign string_end_o = send_q;
  assign run_end_o = rend_q;

endmodule

@@ sv/url_percent_decode.sv @@
// URL percent decoder.
// Input channel (in_valid_i/in_ready_o): one encoded byte per word, in_last_i
// on the final byte of a string. Output channel (out_valid_o/out_ready_i):
// one decoded byte per word; run_end_o marks the last byte caused by one
// input word, string_end_o the last byte of the string.
// The front stage decodes each accepted word combinationally into a run of
// 0..3 bytes and pushes non-empty runs into a 4-entry queue; the back stage
// drains runs into the output register one byte per cycle while it is free.
// The first byte caused by an input word passes through a queue entry and
// then the output register before it is on the output.
// Throughput: one input word per cycle while each word yields at most one
// byte and the receiver keeps up; a word that yields several bytes sends
// them one byte per cycle from the output register while they are taken.
// in_ready_o drops only when the queue is full, so a stalled receiver backs
// up through the queue before the source is held off.
// Reset clears the pending escape state, the queue and the output valid flag.
module url_percent_decode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       string_end_o,
  output logic       run_end_o
);
  import upd_pkg::*;

  logic accept, push, pop, full, empty;
  run_t push_run, head;

  assign in_ready_o = !full;
  assign accept = in_valid_i && !full;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (push),
    .run_o     (push_run)
  );

  upd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .string_end_o (string_end_o),
    .run_end_o    (run_end_o)
  );

endmodule

@@ tb/url_percent_decode_checker.sv @@
module url_percent_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        string_end_i,
  input  logic        run_end_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned words_in_o,
  output int unsigned words_out_o,
  output int unsigned escapes_o,
  output int unsigned broken_o,
  output int unsigned strings_o
);
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       str_end;
    logic       run_end;
  } dec_word_t;

  dec_word_t   exp_words[$];
  logic [1:0]  esc_state;   // 0 idle, 1 '%' held, 2 '%' plus one digit held
  logic [7:0]  held_digit;
  int unsigned fails, n_in, n_out, n_esc, n_broken, n_str;

  // ASCII hex digit, either case
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    d = 8'h00;
    hex_nibble = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
    end else begin
      hex_nibble = 1'b0;
    end
    v = d[3:0];
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic last);
    logic [7:0] run[$];
    logic [3:0] hi, lo;
    logic       restart;
    dec_word_t  w;
    restart = 1'b0;
    case (esc_state)
      2'd1: begin
        if (hex_nibble(b, hi)) begin
          held_digit = b;
          esc_state  = 2'd2;
        end else begin
          esc_state = 2'd0;
          run.push_back(PctChar);
          restart = 1'b1;
          n_broken++;
        end
      end
      2'd2: begin
        esc_state = 2'd0;
        if (hex_nibble(b, lo) && hex_nibble(held_digit, hi)) begin
          run.push_back({hi, lo});
          n_esc++;
        end else begin
          run.push_back(PctChar);
          run.push_back(held_digit);
          restart = 1'b1;
          n_broken++;
        end
      end
      default: begin
        esc_state = 2'd0;
        restart   = 1'b1;
      end
    endcase
    // breaking byte is handled as if nothing were pending
    if (restart) begin
      if (b == PctChar) begin
        esc_state = 2'd1;
      end else begin
        run.push_back(b);
      end
    end
    if (last) begin
      if (esc_state >= 2'd1) run.push_back(PctChar);
      if (esc_state == 2'd2) run.push_back(held_digit);
      esc_state  = 2'd0;
      held_digit = 8'h00;
      n_str++;
    end
    foreach (run[i]) begin
      if (i < MaxOut) begin
        w.data    = run[i];
        w.run_end = (i == run.size() - 1);
        w.str_end = last && (i == run.size() - 1);
        exp_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    dec_word_t w;
    if (!rst_ni) begin
      exp_words.delete();
      esc_state  = 2'd0;
      held_digit = 8'h00;
      fails      = 0;
      n_in       = 0;
      n_out      = 0;
      n_esc      = 0;
      n_broken   = 0;
      n_str      = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_word(in_byte_i, in_last_i);
        n_in++;
      end
      if (out_valid_i && out_ready_i) begin
        n_out++;
        if (exp_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected word byte=%h string_end=%b run_end=%b",
                     $realtime, out_byte_i, string_end_i, run_end_i);
        end else begin
          w = exp_words.pop_front();
          if (w.data !== out_byte_i || w.str_end !== string_end_i ||
              w.run_end !== run_end_i) begin
            fails++;
            if (fails <= 10)
              $display("%0t: word %0d mismatch exp byte=%h se=%b re=%b got byte=%h se=%b re=%b",
                       $realtime, n_out, w.data, w.str_end, w.run_end,
                       out_byte_i, string_end_i, run_end_i);
          end
        end
      end
    end
    fail_cnt_o  <= fails;
    pending_o   <= exp_words.size();
    words_in_o  <= n_in;
    words_out_o <= n_out;
    escapes_o   <= n_esc;
    broken_o    <= n_broken;
    strings_o   <= n_str;
  end

endmodule

@@ tb/url_percent_decode_tb.sv @@
module url_percent_decode_tb;
  import upd_pkg::*;

  localparam int unsigned NumRandom   = 385;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumDirected = 23;
  // string ends: after FF, %aF, '+', %%, %7, %3G
  localparam logic [0:NumDirected-1] DirLast = 23'b01000001000000010101001;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       string_end_o;
  logic       run_end_o;

  int unsigned fail_cnt, pending, words_in, words_out, escapes, broken, strings;
  int unsigned cycles = 0;
  logic        idle_en;
  logic        stall_go;

  url_percent_decode u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .string_end_o (string_end_o),
    .run_end_o    (run_end_o)
  );

  url_percent_decode_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_i   (out_byte_o),
    .string_end_i (string_end_o),
    .run_end_i    (run_end_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .words_in_o   (words_in),
    .words_out_o  (words_out),
    .escapes_o    (escapes),
    .broken_o     (broken),
    .strings_o    (strings)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random idling, plus one long hold-off once stall_go rises
  initial begin : sink
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(0, 99) < 11);
      end
    end
  end

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return 8'h30 + v;
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_hex(b));
    return b;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin : stim
    logic [7:0]  dir_bytes [NumDirected];
    logic [7:0]  str_q[$];
    int unsigned sent, len, kind;
    logic        stall_phase;
    in_valid_i <= 1'b0;
    in_byte_i  <= 8'h00;
    in_last_i  <= 1'b0;
    idle_en    <= 1'b1;
    stall_go   <= 1'b0;
    stall_phase = 1'b0;
    dir_bytes = '{8'h00, 8'hFF,
                  PctChar, "4", "1", PctChar, "a", "F",
                  PctChar, "g", PctChar, "4", PctChar, "4", "1", "+",
                  PctChar, PctChar, PctChar, "7", PctChar, "3", "G"};
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_word(dir_bytes[i], DirLast[i]);

    sent = 0;
    while (sent < NumRandom) begin
      // long stretch without idling, receiver held off at its start
      if (sent >= 150 && !stall_phase) begin
        stall_phase = 1'b1;
        idle_en  <= 1'b0;
        stall_go <= 1'b1;
      end else if (sent >= 260 && stall_phase) begin
        idle_en <= 1'b1;
      end
      str_q.delete();
      len = $urandom_range(1, 8);
      repeat (len) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          str_q.push_back(PctChar);
          str_q.push_back(rand_hex_char());
          str_q.push_back(rand_hex_char());
        end else if (kind < 50) begin
          str_q.push_back(PctChar);
          str_q.push_back(rand_non_hex());
        end else if (kind < 58) begin
          str_q.push_back(PctChar);
          str_q.push_back(rand_hex_char());
          str_q.push_back(rand_non_hex());
        end else if (kind < 62) begin
          str_q.push_back(PctChar);
        end else if (kind < 66) begin
          str_q.push_back(PctChar);
          str_q.push_back(rand_hex_char());
        end else if (kind < 86) begin
          str_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (str_q[i]) send_word(str_q[i], i == str_q.size() - 1);
      sent += str_q.size();
    end
    in_valid_i <= 1'b0;

    // let the checker count the final word before looking at pending
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d encoded words in %0d strings, %0d decoded words out", words_in, strings,
             words_out);
    $display("%0d escapes decoded, %0d broken escapes passed through", escapes, broken);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
